>>> design/assert_macros.svh
// Assertion macros for the scheduler table RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// when pre holds, post must hold in the same cycle
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> design/tts_pkg.sv
// Shared types and constants for the tick task scheduler table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int TABLE_SIZE = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
  localparam int SLOT_W     = 3;
  localparam int HANDLE_W   = 16;
  localparam int TIME_W     = 16;
  localparam int RUNS_W     = 8;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DEL  = 2'd2,
    CMD_DISP = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DISP
  } state_e;

  // decoded command word as it sits in the queue
  typedef struct packed {
    cmd_e                cmd;
    logic                idx_bad;
    logic [SLOT_W-1:0]   idx;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } res_t;

  // single slot write per cycle
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   idx;
    logic                valid;
    logic                handle_en;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
    logic [RUNS_W-1:0]   runs;
  } slot_wr_t;

endpackage

>>> design/tts_front.sv
// Front end: takes command words off the input stream, decodes them and
// pushes them into the command queue. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tts_pkg::CMD_W-1:0]   in_cmd_i,
  input  logic [tts_pkg::SLOT_W-1:0]  in_idx_i,
  input  logic [tts_pkg::HANDLE_W-1:0] in_handle_i,
  input  logic [tts_pkg::TIME_W-1:0]  in_delay_i,
  input  logic [tts_pkg::TIME_W-1:0]  in_period_i,
  output logic                        push_o,
  input  logic                        push_ready_i,
  output tts_pkg::item_t              item_o
);

  logic           hold_q, hold_d;
  tts_pkg::item_t item_q, item_d;
  logic           accept;

  assign push_o     = hold_q;
  assign item_o     = item_q;
  assign in_ready_o = !hold_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hold_d = hold_q;
    item_d = item_q;
    if (accept) begin
      hold_d         = 1'b1;
      item_d.cmd     = tts_pkg::cmd_e'(in_cmd_i);
      // slot numbers past the table are flagged here so the back end never indexes them
      item_d.idx_bad = {1'b0, in_idx_i} >= (tts_pkg::SLOT_W+1)'(tts_pkg::TABLE_SIZE);
      item_d.idx     = in_idx_i;
      item_d.handle  = in_handle_i;
      item_d.delay   = in_delay_i;
      item_d.period  = in_period_i;
    end else if (push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

>>> design/tts_queue.sv
// Short command queue between front and back end.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  tts_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output tts_pkg::item_t pop_item_o
);

  localparam int PtrW = $clog2(tts_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(tts_pkg::QUEUE_DEPTH + 1);

  tts_pkg::item_t mem_q [tts_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(tts_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(tts_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/tts_back.sv
// Back end: holds the slot table, executes queued commands by walking the slots one per cycle
// (a slot with a result waits while the output is stalled), drives the registered result. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  tts_pkg::item_t cmd_i,
  output logic           busy_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output tts_pkg::res_t  res_o
);

  localparam int N = tts_pkg::TABLE_SIZE;
  localparam logic [tts_pkg::SLOT_W-1:0] LastSlot = tts_pkg::SLOT_W'(N - 1);

  logic [N-1:0]                 valid_q;
  logic [tts_pkg::HANDLE_W-1:0] handle_q [N];
  logic [tts_pkg::TIME_W-1:0]   delay_q  [N];
  logic [tts_pkg::TIME_W-1:0]   period_q [N];
  logic [tts_pkg::RUNS_W-1:0]   runs_q   [N];

  tts_pkg::state_e             state_q, state_d;
  logic [tts_pkg::SLOT_W-1:0]  ptr_q, ptr_d;
  logic                        res_valid_q, res_valid_d;
  tts_pkg::res_t               res_q, res_d;

  logic [N-1:0]                pend;
  logic                        out_free;
  logic                        table_full;
  logic [tts_pkg::SLOT_W-1:0]  free_idx;
  logic                        later_pend;
  tts_pkg::slot_wr_t           wr;
  logic                        emit;

  // current slot under the walk pointer
  logic [tts_pkg::HANDLE_W-1:0] cur_handle;
  logic [tts_pkg::TIME_W-1:0]   cur_delay, cur_period;
  logic [tts_pkg::RUNS_W-1:0]   cur_runs;

  assign cur_handle = handle_q[ptr_q];
  assign cur_delay  = delay_q[ptr_q];
  assign cur_period = period_q[ptr_q];
  assign cur_runs   = runs_q[ptr_q];

  assign out_free    = !res_valid_q || res_ready_i;
  assign table_full  = &valid_q;
  assign busy_o      = state_q != tts_pkg::S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    for (int s = 0; s < N; s++) begin
      pend[s] = valid_q[s] && (runs_q[s] != '0);
    end
  end

  always_comb begin
    free_idx = '0;
    for (int s = N - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_idx = tts_pkg::SLOT_W'(s);
      end
    end
  end

  always_comb begin
    later_pend = 1'b0;
    for (int s = 0; s < N; s++) begin
      if (tts_pkg::SLOT_W'(s) > ptr_q && pend[s]) begin
        later_pend = 1'b1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    res_d     = res_q;
    wr        = '0;
    wr.idx    = ptr_q;

    unique case (state_q)
      tts_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.cmd)
            tts_pkg::CMD_TICK: begin
              state_d = tts_pkg::S_TICK;
              ptr_d   = '0;
            end
            tts_pkg::CMD_ADD: begin
              emit = 1'b1;
              if (table_full) begin
                res_d = '{status: tts_pkg::ST_FULL, slot: '0, handle: '0, last: 1'b1};
              end else begin
                wr.en        = 1'b1;
                wr.idx       = free_idx;
                wr.valid     = 1'b1;
                wr.handle_en = 1'b1;
                wr.handle    = cmd_i.handle;
                wr.delay     = cmd_i.delay;
                wr.period    = cmd_i.period;
                wr.runs      = '0;
                res_d = '{status: tts_pkg::ST_OK, slot: free_idx, handle: '0, last: 1'b1};
              end
            end
            tts_pkg::CMD_DEL: begin
              emit = 1'b1;
              if (cmd_i.idx_bad || !valid_q[cmd_i.idx]) begin
                res_d = '{status: tts_pkg::ST_EMPTY, slot: cmd_i.idx, handle: '0,
                          last: 1'b1};
              end else begin
                wr.en  = 1'b1;
                wr.idx = cmd_i.idx;
                res_d = '{status: tts_pkg::ST_OK, slot: cmd_i.idx, handle: '0, last: 1'b1};
              end
            end
            tts_pkg::CMD_DISP: begin
              if (pend == '0) begin
                emit  = 1'b1;
                res_d = '{status: tts_pkg::ST_NONE, slot: '0, handle: '0, last: 1'b1};
              end else begin
                state_d = tts_pkg::S_DISP;
                ptr_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end

      tts_pkg::S_TICK: begin
        // last slot also sends the result, so it waits for the output register
        if (ptr_q != LastSlot || out_free) begin
          if (valid_q[ptr_q]) begin
            wr.en        = 1'b1;
            wr.valid     = 1'b1;
            wr.period    = cur_period;
            wr.runs      = cur_runs;
            if (cur_delay == '0) begin
              if (cur_runs != tts_pkg::RUNS_MAX) begin
                wr.runs = cur_runs + 1'b1;
              end
              wr.delay = cur_period;
            end else begin
              wr.delay = cur_delay - 1'b1;
            end
          end
          if (ptr_q == LastSlot) begin
            emit    = 1'b1;
            res_d   = '{status: tts_pkg::ST_OK, slot: '0, handle: '0, last: 1'b1};
            state_d = tts_pkg::S_IDLE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end

      tts_pkg::S_DISP: begin
        if (!pend[ptr_q]) begin
          ptr_d = ptr_q + 1'b1;
        end else if (out_free) begin
          emit  = 1'b1;
          res_d = '{status: tts_pkg::ST_OK, slot: ptr_q, handle: cur_handle,
                    last: !later_pend};
          wr.en = 1'b1;
          // one-shot tasks leave the table on dispatch
          if (cur_period != '0) begin
            wr.valid  = 1'b1;
            wr.delay  = cur_delay;
            wr.period = cur_period;
            wr.runs   = cur_runs - 1'b1;
          end
          if (!later_pend) begin
            state_d = tts_pkg::S_IDLE;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
      end

      default: state_d = tts_pkg::S_IDLE;
    endcase

    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tts_pkg::S_IDLE;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int s = 0; s < N; s++) begin
        delay_q[s]  <= '0;
        period_q[s] <= '0;
        runs_q[s]   <= '0;
      end
    end else if (wr.en) begin
      valid_q[wr.idx]  <= wr.valid;
      delay_q[wr.idx]  <= wr.delay;
      period_q[wr.idx] <= wr.period;
      runs_q[wr.idx]   <= wr.runs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en && wr.handle_en) begin
      handle_q[wr.idx] <= wr.handle;
    end
  end

endmodule

>>> design/tick_task_scheduler_table.sv
// Tick task scheduler table, top level.
// Command stream in, result stream out; commands are decoded by the front
// end, queued, and executed against an eight-slot task table by the back end.
// Channels: s_axis carries one command word (tuser = command), m_axis one
// result word (tuser = status, tlast = final result of the command).
// Add, delete and an empty dispatch pass through the front register, the
// queue and the result register. A tick walks all eight slots, one per
// cycle, waits at the last slot for a free output and answers with one word.
// A dispatch walks the slots from 0 up, one per cycle, waiting at each
// pending slot for a free output; one word per pending slot.
// Throughput: one command in the back end at a time, so add/delete run at
// one per cycle while the output is not stalled; a tick or a dispatch holds
// the back end for its whole walk through the single table write port.
// The queue holds two commands plus one in the front register, so the
// input keeps taking words while a result waits on the output.
// Reset: table cleared (no valid slots, all counts zero), queue empty.
// When the receiver stalls, the result word holds and the back end stops
// at the next result; commands back up into the queue, then tready drops.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tick_task_scheduler_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] slot_index, [18:3] task_handle, [34:19] start_delay,
  // [50:35] repeat_period, [55:51] zero
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] result_slot, [18:3] result_handle, [23:19] zero
  output logic [23:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o,
  // last_result
  output logic        m_axis_tlast_o
);

  logic           fr_push, q_ready, q_valid, q_pop, bk_busy;
  logic           err_word, bk_active;
  tts_pkg::item_t fr_item, q_item;
  tts_pkg::res_t  res;

  tts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_idx_i     (s_axis_tdata_i[2:0]),
    .in_handle_i  (s_axis_tdata_i[18:3]),
    .in_delay_i   (s_axis_tdata_i[34:19]),
    .in_period_i  (s_axis_tdata_i[50:35]),
    .push_o       (fr_push),
    .push_ready_i (q_ready),
    .item_o       (fr_item)
  );

  tts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fr_push),
    .push_ready_o (q_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  tts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_item),
    .busy_o      (bk_busy),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {5'b0, res.handle, res.slot};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.last;

  assign err_word  = m_axis_tvalid_o && m_axis_tuser_o != tts_pkg::ST_OK;
  assign bk_active = q_valid || bk_busy;

  // error and idle answers are always the only word of their command
  `ASSERT_IMPLY(a_err_is_last, err_word, m_axis_tlast_o, "status word without tlast")
  `ASSERT_IMPLY(a_err_no_handle, err_word, m_axis_tdata_o[18:3] == '0, "status word has handle")
  // a new result needs a command in the queue or a walk in progress
  `ASSERT_IMPLY(a_res_has_cause, $rose(m_axis_tvalid_o), $past(bk_active), "result without cause")

endmodule

>>> dv/tick_task_scheduler_table_checker.sv
// Scoreboard for the tick task scheduler table: watches both stream channels,
// keeps a mirror of the task table and compares every result word in order.
// Depends on tts_pkg for the command and status codes and the table size.
`timescale 1ns / 1ps

module tick_task_scheduler_table_checker
  import tts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  // [2:0] slot_index, [18:3] task_handle, [34:19] start_delay,
  // [50:35] repeat_period, [55:51] zero
  input  logic [55:0] in_data_i,
  // [1:0] command
  input  logic [1:0]  in_cmd_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  // [2:0] result_slot, [18:3] result_handle, [23:19] zero
  input  logic [23:0] out_data_i,
  // [1:0] status
  input  logic [1:0]  out_status_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_o,
  output int          commands_o,
  output int          disp_hits_o,
  output int          full_hits_o,
  output int          sat_hits_o
);

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } sched_word_t;

  // mirror of the task table
  logic                tbl_valid  [TABLE_SIZE];
  logic [HANDLE_W-1:0] tbl_handle [TABLE_SIZE];
  logic [TIME_W-1:0]   tbl_delay  [TABLE_SIZE];
  logic [TIME_W-1:0]   tbl_period [TABLE_SIZE];
  logic [RUNS_W-1:0]   tbl_runs   [TABLE_SIZE];

  sched_word_t expected_words[$];

  function automatic sched_word_t make_word(status_e st, int slot, logic [HANDLE_W-1:0] h,
                                            logic last);
    sched_word_t w;
    w.status = st;
    w.slot   = slot[SLOT_W-1:0];
    w.handle = h;
    w.last   = last;
    return w;
  endfunction

  task automatic free_slot(input int s);
    tbl_valid[s]  = 1'b0;
    tbl_delay[s]  = '0;
    tbl_period[s] = '0;
    tbl_runs[s]   = '0;
  endtask

  // apply one command to the mirror and queue the words it must produce
  task automatic predict_command(input cmd_e c, input logic [SLOT_W-1:0] idx,
                                 input logic [HANDLE_W-1:0] h,
                                 input logic [TIME_W-1:0] d, input logic [TIME_W-1:0] p);
    int  s;
    int  base;
    bit  placed;
    base   = expected_words.size();
    placed = 1'b0;
    case (c)
      CMD_TICK: begin
        for (s = 0; s < TABLE_SIZE; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_delay[s] == '0) begin
              if (tbl_runs[s] != RUNS_MAX) tbl_runs[s] = tbl_runs[s] + 1'b1;
              else sat_hits_o++;
              if (tbl_period[s] != '0) tbl_delay[s] = tbl_period[s];
            end else begin
              tbl_delay[s] = tbl_delay[s] - 1'b1;
            end
          end
        end
        expected_words.push_back(make_word(ST_OK, 0, '0, 1'b1));
      end
      CMD_ADD: begin
        for (s = 0; s < TABLE_SIZE && !placed; s++) begin
          if (!tbl_valid[s]) begin
            tbl_valid[s]  = 1'b1;
            tbl_handle[s] = h;
            tbl_delay[s]  = d;
            tbl_period[s] = p;
            tbl_runs[s]   = '0;
            placed = 1'b1;
            expected_words.push_back(make_word(ST_OK, s, '0, 1'b1));
          end
        end
        if (!placed) begin
          full_hits_o++;
          expected_words.push_back(make_word(ST_FULL, 0, '0, 1'b1));
        end
      end
      CMD_DEL: begin
        if (int'(idx) >= TABLE_SIZE || !tbl_valid[idx]) begin
          expected_words.push_back(make_word(ST_EMPTY, int'(idx), '0, 1'b1));
        end else begin
          free_slot(int'(idx));
          expected_words.push_back(make_word(ST_OK, int'(idx), '0, 1'b1));
        end
      end
      default: begin
        for (s = 0; s < TABLE_SIZE; s++) begin
          if (tbl_valid[s] && tbl_runs[s] != '0) begin
            expected_words.push_back(make_word(ST_OK, s, tbl_handle[s], 1'b0));
            disp_hits_o++;
            tbl_runs[s] = tbl_runs[s] - 1'b1;
            // one-shot leaves the table at its first dispatch
            if (tbl_period[s] == '0) free_slot(s);
          end
        end
        if (expected_words.size() == base)
          expected_words.push_back(make_word(ST_NONE, 0, '0, 1'b1));
        else
          expected_words[expected_words.size()-1].last = 1'b1;
      end
    endcase
  endtask

  task automatic note_mismatch(input string field, input int exp_v, input int act_v);
    $display("%0t: result word %0d field %s mismatch: expected 0x%0h, got 0x%0h",
             $time, words_o, field, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_word_t want;
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_SIZE; s++) begin
        free_slot(s);
        tbl_handle[s] = '0;
      end
      expected_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_o      = 0;
      commands_o   = 0;
      disp_hits_o  = 0;
      full_hits_o  = 0;
      sat_hits_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: status %0d slot %0d handle 0x%h last %b",
                   $time, out_status_i, out_data_i[2:0], out_data_i[18:3], out_last_i);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (out_status_i != want.status)
            note_mismatch("status", int'(want.status), int'(out_status_i));
          if (out_data_i[2:0] != want.slot)
            note_mismatch("result_slot", int'(want.slot), int'(out_data_i[2:0]));
          if (out_data_i[18:3] != want.handle)
            note_mismatch("result_handle", int'(want.handle), int'(out_data_i[18:3]));
          if (out_last_i != want.last)
            note_mismatch("last_result", int'(want.last), int'(out_last_i));
          if (out_data_i[23:19] != '0)
            note_mismatch("tdata padding", 0, int'(out_data_i[23:19]));
        end
        words_o++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_command(cmd_e'(in_cmd_i), in_data_i[2:0], in_data_i[18:3],
                        in_data_i[34:19], in_data_i[50:35]);
        commands_o++;
      end
      pending_o = expected_words.size();
    end
  end

endmodule

>>> dv/tick_task_scheduler_table_test.sv
// Top of the tick task scheduler table testbench: clock, reset, command
// stimulus with bursty sending and a stalling receiver, and the verdict.
// Depends on tts_pkg, the block and tick_task_scheduler_table_checker.
`timescale 1ns / 1ps

module tick_task_scheduler_table_test;
  import tts_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int RANDOM_WORDS = 195;
  localparam int HOLD_CYCLES  = 300;
  localparam int SOAK_TICKS   = 262;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic [1:0]  s_cmd = CMD_TICK;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [1:0]  m_status;
  logic        m_last;

  int fail_count, pending, words, commands, disp_hits, full_hits, sat_hits;
  int cycles = 0;
  int words_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tick_task_scheduler_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_cmd),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_status),
    .m_axis_tlast_o  (m_last)
  );

  tick_task_scheduler_table_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_cmd_i     (s_cmd),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_status_i (m_status),
    .out_last_i   (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words),
    .commands_o   (commands),
    .disp_hits_o  (disp_hits),
    .full_hits_o  (full_hits),
    .sat_hits_o   (sat_hits)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("tick_task_scheduler_table test failed");
      $finish;
    end
  end

  // mostly short times so countdowns actually expire; sometimes any 16-bit value
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 3));
      6, 7:             return 16'($urandom_range(4, 12));
      8:                return 16'($urandom_range(0, 16'hFFFF));
      default:          return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // offer one command word and hold it until taken; bursts with random gaps
  task automatic issue(input cmd_e c, input logic [2:0] idx, input logic [15:0] h,
                       input logic [15:0] d, input logic [15:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_cmd   <= c;
    s_data  <= {5'b0, p, d, h, idx};
    do @(posedge clk_i); while (!s_ready);
    words_sent++;
  endtask

  task automatic issue_any(input cmd_e c);
    issue(c, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 16'hFFFF)),
          pick_time(), pick_time());
  endtask

  // receiver: changes stall pattern every stretch, one long hold-off on request
  initial begin
    int  mode;
    int  len;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req && !held) begin
        @(posedge clk_i);
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= ~m_ready;
        endcase
      end
    end
  end

  initial begin
    logic [15:0] soak_handle;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table corners, extreme fields, full table, delete paths
    issue(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DISP, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(CMD_DEL,  3'd5, 16'h1234, 16'h0000, 16'h0000);
    issue(CMD_ADD,  3'd7, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_ADD,  3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(CMD_ADD,  3'd2, 16'hA5A5, 16'h0000, 16'h0001);
    issue(CMD_ADD,  3'd5, 16'h5A5A, 16'h0001, 16'h0000);
    issue(CMD_ADD,  3'd1, 16'h0F0F, 16'h0002, 16'hFFFF);
    issue(CMD_ADD,  3'd6, 16'hF0F0, 16'h0000, 16'h0002);
    issue(CMD_ADD,  3'd3, 16'h8001, 16'h0000, 16'h0000);
    issue(CMD_ADD,  3'd4, 16'h7FFE, 16'h0003, 16'h0001);
    issue(CMD_ADD,  3'd0, 16'hDEAD, 16'h0000, 16'h0000);
    issue(CMD_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DEL,  3'd7, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DEL,  3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(CMD_ADD,  3'd0, 16'h00FF, 16'h0000, 16'h0000);
    issue(CMD_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DEL,  3'd1, 16'h0000, 16'h0000, 16'h0000);
    issue(CMD_DISP, 3'd0, 16'h0000, 16'h0000, 16'h0000);

    // random: mostly add/tick/dispatch rounds, some raw noise
    hold_req = 1'b1;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 3)) issue_any(CMD_ADD);
        repeat ($urandom_range(1, 6)) issue_any(CMD_TICK);
        issue_any(CMD_DISP);
        if ($urandom_range(0, 2) == 0) issue_any(CMD_DEL);
      end else begin
        repeat ($urandom_range(1, 4)) issue_any(cmd_e'($urandom_range(0, 3)));
      end
    end

    // soak: empty the table, then let run counts pile up past saturation
    for (int s = 0; s < TABLE_SIZE; s++)
      issue(CMD_DEL, s[2:0], 16'h0000, 16'h0000, 16'h0000);
    soak_handle = 16'($urandom_range(0, 16'hFFFF));
    issue(CMD_ADD, 3'd0, soak_handle, 16'h0000, 16'h0000);
    issue(CMD_ADD, 3'd0, ~soak_handle, 16'h0000, 16'h0001);
    repeat (SOAK_TICKS) issue_any(CMD_TICK);
    issue_any(CMD_DISP);
    issue_any(CMD_DISP);
    issue_any(CMD_DISP);

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("%0d commands and %0d result words checked in %0d cycles",
             commands, words, cycles);
    $display("%0d dispatch hits, %0d adds on a full table, %0d ticks at saturated count",
             disp_hits, full_hits, sat_hits);
    if (fail_count == 0) begin
      $display("tick_task_scheduler_table test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tick_task_scheduler_table test failed");
    end
    $finish;
  end

endmodule
